### rtl/core/dris_pkg.sv
`default_nettype none
package dris_pkg;

	// operation codes carried in the input item
	localparam logic [1:0] OP_SEED  = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_DRAW  = 2'd2;

	// twister constants
	localparam int unsigned MT_N = 624;
	localparam logic [9:0] MT_LAST   = 10'd623;
	localparam logic [9:0] MT_M      = 10'd397;
	localparam logic [9:0] MT_WRAP   = 10'd227;
	localparam logic [31:0] MT_MAG   = 32'h9908_B0DF;
	localparam logic [31:0] MT_MULT  = 32'd1812433253;
	localparam logic [31:0] MT_DEF_SEED = 32'd5489;
	localparam logic [30:0] SEED_RESET  = 31'd5489;

	// requests into the twister
	typedef struct packed {
		logic seed;
		logic next;
	} tw_req_t;

	// status back from the twister
	typedef struct packed {
		logic busy;
		logic done;
	} tw_stat_t;

endpackage
`default_nettype wire

### rtl/core/dris_ram.sv
`default_nettype none
module dris_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/core/dris_twister.sv
`default_nettype none
module dris_twister import dris_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire tw_req_t     req,
	input  wire logic [31:0] seed,
	output tw_stat_t         stat,
	output logic [31:0]      word
);

	typedef enum logic [7:0] {
		TW_IDLE  = 8'b0000_0001,
		TW_SEED0 = 8'b0000_0010,
		TW_SMUL  = 8'b0000_0100,
		TW_SADD  = 8'b0000_1000,
		TW_RA    = 8'b0001_0000,
		TW_RB    = 8'b0010_0000,
		TW_RC    = 8'b0100_0000,
		TW_RD    = 8'b1000_0000
	} tw_state_t;

	tw_state_t   state_q;
	logic [31:0] seed_lat_q;
	logic [31:0] prev_q;
	logic [31:0] prod_q;
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic [31:0] word_q;
	logic [9:0]  i_q;
	logic [9:0]  pos_q;
	logic        done_q;

	logic        we;
	logic [9:0]  waddr;
	logic [31:0] wdata;
	logic [9:0]  raddr;
	logic [31:0] rdata;
	logic [9:0]  pos_p1;
	logic [9:0]  pos_m;
	logic [31:0] y;
	logic [31:0] new_w;
	logic [31:0] sum_w;

	function automatic logic [31:0] temper(input logic [31:0] v);
		logic [31:0] t;
		t = v ^ (v >> 11);
		t = t ^ ((t << 7) & 32'h9D2C_5680);
		t = t ^ ((t << 15) & 32'hEFC6_0000);
		t = t ^ (t >> 18);
		return t;
	endfunction

	assign pos_p1 = (pos_q == MT_LAST) ? 10'd0 : pos_q + 10'd1;
	assign pos_m  = (pos_q < MT_WRAP) ? pos_q + MT_M : pos_q - MT_WRAP;
	assign y      = {a_q[31], b_q[30:0]};
	assign new_w  = rdata ^ (y >> 1) ^ (y[0] ? MT_MAG : 32'd0);
	assign sum_w  = prod_q + {22'd0, i_q};

	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = new_w;
		raddr = pos_q;
		case (state_q)
			TW_SEED0: begin
				we    = 1'b1;
				waddr = 10'd0;
				wdata = seed_lat_q;
			end
			TW_SADD: begin
				we    = 1'b1;
				waddr = i_q;
				wdata = sum_w;
			end
			TW_RB: raddr = pos_p1;
			TW_RC: raddr = pos_m;
			TW_RD: we = 1'b1;
			default: ;
		endcase
	end

	dris_ram #(.WIDTH(32), .DEPTH(MT_N)) u_words (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= TW_SEED0;
			seed_lat_q <= MT_DEF_SEED;
			i_q        <= 10'd1;
			pos_q      <= 10'd0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				TW_IDLE: begin
					if (req.seed) begin
						seed_lat_q <= seed;
						state_q    <= TW_SEED0;
					end else if (req.next) begin
						state_q <= TW_RA;
					end
				end
				TW_SEED0: begin
					i_q     <= 10'd1;
					pos_q   <= 10'd0;
					state_q <= TW_SMUL;
				end
				TW_SMUL: state_q <= TW_SADD;
				TW_SADD: begin
					if (i_q == MT_LAST) begin
						done_q  <= 1'b1;
						state_q <= TW_IDLE;
					end else begin
						i_q     <= i_q + 10'd1;
						state_q <= TW_SMUL;
					end
				end
				TW_RA: state_q <= TW_RB;
				TW_RB: state_q <= TW_RC;
				TW_RC: state_q <= TW_RD;
				TW_RD: begin
					pos_q   <= pos_p1;
					done_q  <= 1'b1;
					state_q <= TW_IDLE;
				end
				default: state_q <= TW_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			TW_SEED0: prev_q <= seed_lat_q;
			TW_SMUL:  prod_q <= MT_MULT * (prev_q ^ (prev_q >> 30));
			TW_SADD:  prev_q <= sum_w;
			TW_RB:    a_q <= rdata;
			TW_RC:    b_q <= rdata;
			TW_RD:    word_q <= temper(new_w);
			default: ;
		endcase
	end

	assign stat.busy = (state_q != TW_IDLE);
	assign stat.done = done_q;
	assign word      = word_q;

endmodule
`default_nettype wire

### rtl/core/dris_mod.sv
`default_nettype none
module dris_mod (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [12:0] divisor,
	output logic             done,
	output logic [12:0]      rem
);

	logic [31:0] x_q;
	logic [12:0] d_q;
	logic [12:0] r_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [13:0] sh;
	logic [13:0] diff;

	// restoring remainder, one dividend bit a cycle
	assign sh   = {r_q, x_q[31]};
	assign diff = sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 6'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 6'd32;
			end else if (cnt_q != 6'd0) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= dividend;
			d_q <= divisor;
			r_q <= 13'd0;
		end else if (cnt_q != 6'd0) begin
			x_q <= {x_q[30:0], 1'b0};
			r_q <= (sh >= {1'b0, d_q}) ? diff[12:0] : sh[12:0];
		end
	end

	assign done = done_q;
	assign rem  = r_q;

endmodule
`default_nettype wire

### rtl/core/distinct_random_index_sampler.sv
// draw: a twister word, then the bit-serial remainder, then the used-map look-up,
//   repeated on every rejected try, then the result is loaded; a draw
//   that takes the lowest free index also scans the map forward, one entry at a time
// reseed: each word of the state is computed through the seeding multiplier
// clear: one map entry a cycle; an exhausted draw goes straight to the result
// after reset the map is cleared while the twister seeds from 5489
`default_nettype none
module distinct_random_index_sampler import dris_pkg::*; #(
	parameter int MAX_SPACE = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// seed register write
	input  wire logic        cfg_we,
	input  wire logic [30:0] cfg_wdata,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // op [1:0], span [14:2], zero [15]
	// result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata    // index [11:0], exhausted [12], zero [15:13]
);

	localparam int AW = (MAX_SPACE > 1) ? $clog2(MAX_SPACE) : 1;
	// wide enough for the span field and for MAX_SPACE itself
	localparam int CW = (AW + 1 > 13) ? AW + 1 : 13;
	localparam logic [CW-1:0] MAXV = CW'(MAX_SPACE);
	localparam logic [CW-1:0] LASTV = CW'(MAX_SPACE - 1);

	typedef enum logic [10:0] {
		T_INIT = 11'b000_0000_0001,
		T_IDLE = 11'b000_0000_0010,
		T_SEED = 11'b000_0000_0100,
		T_CLR  = 11'b000_0000_1000,
		T_NEXT = 11'b000_0001_0000,
		T_MOD  = 11'b000_0010_0000,
		T_MRD  = 11'b000_0100_0000,
		T_MCHK = 11'b000_1000_0000,
		T_SRD  = 11'b001_0000_0000,
		T_SCK  = 11'b010_0000_0000,
		T_OUT  = 11'b100_0000_0000
	} top_state_t;

	top_state_t  state_q;
	logic [30:0] seed_q;
	logic [CW-1:0] clr_q;        // clearing pass address
	logic          clr_done_q;
	logic [CW-1:0] min_free_q;   // lowest index not yet marked
	logic [CW-1:0] n_q;          // saturated span of the current draw
	logic [11:0]   res_idx_q;
	logic          res_ex_q;
	logic [15:0]   m_data_q;
	logic          m_valid_q;

	logic [1:0]    in_op;
	logic [12:0]   in_space;
	logic [CW-1:0] in_space_w;
	logic [CW-1:0] n_sat;
	logic          accept;

	tw_req_t       tw_req;
	tw_stat_t      tw_stat;
	logic [31:0]   tw_word;
	logic          mod_start;
	logic          mod_done;
	logic [12:0]   mod_rem;
	logic [CW-1:0] rem_w;
	logic [CW-1:0] mf_p1;

	logic          map_we;
	logic [AW-1:0] map_waddr;
	logic          map_wdata;
	logic [AW-1:0] map_raddr;
	logic          map_rdata;

	assign in_op      = s_tdata[1:0];
	assign in_space   = s_tdata[14:2];
	assign in_space_w = CW'(in_space);
	// spans above the map depth are saturated
	assign n_sat      = (in_space_w > MAXV) ? MAXV : in_space_w;
	assign s_tready   = (state_q == T_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign rem_w      = CW'(mod_rem);
	assign mf_p1      = min_free_q + CW'(1);

	// twister requests: reseed on an accepted seed item, next word on a draw that is not exhausted and on each rejection
	always_comb begin
		tw_req.seed = accept && (in_op == OP_SEED);
		tw_req.next = (accept && (in_op == OP_DRAW) && (min_free_q < n_sat)) ||
		              ((state_q == T_MCHK) && map_rdata);
	end

	assign mod_start = (state_q == T_NEXT) && tw_stat.done;

	dris_twister u_twister (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tw_req),
		.seed   ({1'b0, seed_q}),
		.stat   (tw_stat),
		.word   (tw_word)
	);

	dris_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (tw_word),
		.divisor  (n_q[12:0]),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// used map port selection
	always_comb begin
		map_we    = 1'b0;
		map_waddr = clr_q[AW-1:0];
		map_wdata = 1'b0;
		map_raddr = rem_w[AW-1:0];
		case (state_q)
			T_INIT: map_we = !clr_done_q;
			T_CLR:  map_we = 1'b1;
			T_MCHK: begin
				// mark the index when it was free
				map_we    = !map_rdata;
				map_waddr = rem_w[AW-1:0];
				map_wdata = 1'b1;
			end
			T_SRD:  map_raddr = min_free_q[AW-1:0];
			default: ;
		endcase
	end

	dris_ram #(.WIDTH(1), .DEPTH(MAX_SPACE)) u_used_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	// seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= T_INIT;
			clr_q      <= '0;
			clr_done_q <= 1'b0;
			min_free_q <= '0;
		end else begin
			case (state_q)
				T_INIT: begin
					if (!clr_done_q) begin
						if (clr_q == LASTV) begin
							clr_done_q <= 1'b1;
						end else begin
							clr_q <= clr_q + CW'(1);
						end
					end else if (!tw_stat.busy) begin
						state_q <= T_IDLE;
					end
				end
				T_IDLE: begin
					if (accept) begin
						case (in_op)
							OP_SEED:  state_q <= T_SEED;
							OP_CLEAR: begin
								clr_q   <= '0;
								state_q <= T_CLR;
							end
							OP_DRAW: begin
								// no free index below the size: flag exhaustion
								state_q <= (min_free_q < n_sat) ? T_NEXT : T_OUT;
							end
							default:  state_q <= T_OUT;
						endcase
					end
				end
				T_SEED: begin
					if (tw_stat.done) begin
						state_q <= T_OUT;
					end
				end
				T_CLR: begin
					if (clr_q == LASTV) begin
						min_free_q <= '0;
						state_q    <= T_OUT;
					end else begin
						clr_q <= clr_q + CW'(1);
					end
				end
				T_NEXT: begin
					if (tw_stat.done) begin
						state_q <= T_MOD;
					end
				end
				T_MOD: begin
					if (mod_done) begin
						state_q <= T_MRD;
					end
				end
				T_MRD: state_q <= T_MCHK;
				T_MCHK: begin
					if (map_rdata) begin
						state_q <= T_NEXT;          // already used: try again
					end else if (rem_w == min_free_q) begin
						min_free_q <= mf_p1;
						state_q    <= (mf_p1 == MAXV) ? T_OUT : T_SRD;
					end else begin
						state_q <= T_OUT;
					end
				end
				T_SRD: state_q <= T_SCK;
				T_SCK: begin
					if (!map_rdata) begin
						state_q <= T_OUT;
					end else begin
						min_free_q <= mf_p1;
						state_q    <= (mf_p1 == MAXV) ? T_OUT : T_SRD;
					end
				end
				T_OUT: begin
					if (!m_valid_q || m_tready) begin
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_idx_q <= 12'd0;
			res_ex_q  <= (in_op == OP_DRAW) && !(min_free_q < n_sat);
			n_q       <= n_sat;
		end else if ((state_q == T_MCHK) && !map_rdata) begin
			res_idx_q <= mod_rem[11:0];
		end
	end

	// output register, loaded when the slot is free or being emptied
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if ((state_q == T_OUT) && (!m_valid_q || m_tready)) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == T_OUT) && (!m_valid_q || m_tready)) begin
			m_data_q <= {3'd0, res_ex_q, res_idx_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule
`default_nettype wire
